[sv/tcprtt_pkg.sv]
package tcprtt_pkg;

    localparam int TimeW = 48;
    localparam int SeqW  = 32;
    localparam int RttW  = 32;
    localparam int LenW  = 16;
    localparam int EvW   = 3;
    localparam int PendW = 8;

    localparam logic [EvW-1:0] EV_NONE    = 3'd0;
    localparam logic [EvW-1:0] EV_SYN     = 3'd1;
    localparam logic [EvW-1:0] EV_CONN    = 3'd2;
    localparam logic [EvW-1:0] EV_TRACKED = 3'd3;
    localparam logic [EvW-1:0] EV_DATA    = 3'd4;
    localparam logic [EvW-1:0] EV_FULL    = 3'd5;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SYN,
        OP_SYNACK,
        OP_DATA,
        OP_ACK
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [TimeW-1:0] time_us;
        logic [SeqW-1:0]  key;
    } t_cmd;

    typedef struct packed {
        logic [SeqW-1:0]  seq;
        logic [TimeW-1:0] ts;
    } t_entry;

    function automatic logic [RttW-1:0] f_elapsed(input logic [TimeW-1:0] now,
                                                   input logic [TimeW-1:0] then_us);
        logic [TimeW-1:0] d;
        d = (now >= then_us) ? now - then_us : '0;
        return (d > TimeW'({RttW{1'b1}})) ? {RttW{1'b1}} : d[RttW-1:0];
    endfunction

endpackage

[sv/tcprtt_if.sv]
interface tcprtt_seg_if
    import tcprtt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [TimeW-1:0] time_us;
    logic             syn_flag;
    logic             ack_flag;
    logic [SeqW-1:0]  seq_number;
    logic [SeqW-1:0]  ack_number;
    logic [LenW-1:0]  payload_len;

    modport source (output valid, time_us, syn_flag, ack_flag, seq_number, ack_number,
                    payload_len, input ready);
    modport sink (input valid, time_us, syn_flag, ack_flag, seq_number, ack_number,
                  payload_len, output ready);
endinterface

interface tcprtt_res_if
    import tcprtt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [EvW-1:0]   event_res;
    logic [RttW-1:0]  sample_rtt_us;
    logic [RttW-1:0]  avg_rtt_us;
    logic             avg_valid;
    logic [PendW-1:0] pending_entries;

    modport source (output valid, event_res, sample_rtt_us, avg_rtt_us, avg_valid,
                    pending_entries, input ready);
    modport sink (input valid, event_res, sample_rtt_us, avg_rtt_us, avg_valid,
                  pending_entries, output ready);
endinterface

[sv/tcprtt_front.sv]
module tcprtt_front
    import tcprtt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcprtt_seg_if.sink   i_seg,
    output logic         o_cmd_valid,
    output t_cmd         o_cmd,
    input  logic         i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    always_comb begin
        w_cmd.time_us = i_seg.time_us;
        w_cmd.key     = i_seg.seq_number;
        if (i_seg.syn_flag && !i_seg.ack_flag) begin
            w_cmd.op = OP_SYN;
        end else if (i_seg.syn_flag) begin
            w_cmd.op = OP_SYNACK;
        end else if (i_seg.ack_flag) begin
            w_cmd.op  = OP_ACK;
            w_cmd.key = i_seg.ack_number;
        end else if (i_seg.payload_len != '0) begin
            w_cmd.op = OP_DATA;
        end else begin
            w_cmd.op = OP_NONE;
        end
    end

    assign i_seg.ready = (r_cnt != 2'd2);
    assign w_push      = i_seg.valid && i_seg.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_cmd;
                r_wp      <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        end
    end

endmodule

[sv/tcprtt_back.sv]
module tcprtt_back
    import tcprtt_pkg::*;
#(
    parameter int PENDING_DEPTH = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_cmd_pop,
    tcprtt_res_if.source  o_res
);

    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int DivW = TimeW;
    localparam int DcW = $clog2(DivW + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_AVG,
        S_EMIT
    } t_state;

    t_entry            mem [PENDING_DEPTH];
    t_entry            r_rdata;
    t_state            r_state;
    logic [1:0]        r_phase;
    logic [TimeW-1:0]  r_syn_ts;
    logic [RttW-1:0]   r_conn;
    logic [CW-1:0]     r_total;
    logic [TimeW-1:0]  r_dsum;
    logic [RttW-1:0]   r_nsamp;
    logic [RttW-1:0]   r_avg;
    logic [TimeW-1:0]  r_mean;
    logic [EvW-1:0]    r_ev;
    logic [RttW-1:0]   r_sample;
    logic [TimeW-1:0]  r_now;
    logic [SeqW-1:0]   r_ackn;
    logic [CW-1:0]     r_addr;
    logic [AW-1:0]     r_daddr;
    logic              r_dv;
    logic              r_found;
    logic [DivW-1:0]   r_dvd;
    logic [RttW:0]     r_rem;
    logic [DcW-1:0]    r_dcnt;
    logic              r_out_valid;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    t_entry            w_wdata;
    logic              w_match;
    logic [TimeW:0]    w_sum;
    logic [RttW:0]     w_rem_sh;
    logic              w_qbit;
    logic [TimeW:0]    w_comb;
    logic [TimeW-1:0]  w_v;

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid && !r_out_valid;
    assign w_match   = r_dv && !r_found && (r_ackn > r_rdata.seq);
    assign w_sum     = {1'b0, r_dsum} + (TimeW + 1)'(r_sample);
    assign w_rem_sh  = {r_rem[RttW-1:0], r_dvd[DivW-1]};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_nsamp});
    assign w_comb    = (TimeW + 1)'(r_conn) + {1'b0, r_mean};

    always_comb begin
        if (r_nsamp != '0) begin
            w_v = (r_conn != '0) ? w_comb[TimeW:1] : r_mean;
        end else begin
            w_v = TimeW'(r_conn);
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_daddr - AW'(1);
        w_wdata = r_rdata;
        if (r_state == S_SCAN) begin
            w_we = r_dv && r_found;
        end else if (o_cmd_pop && i_cmd.op == OP_DATA && r_total < CW'(PENDING_DEPTH)) begin
            w_we          = 1'b1;
            w_waddr       = r_total[AW-1:0];
            w_wdata.seq   = i_cmd.key;
            w_wdata.ts    = i_cmd.time_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 2'd0;
            r_syn_ts    <= '0;
            r_conn      <= '0;
            r_total     <= '0;
            r_dsum      <= '0;
            r_nsamp     <= '0;
            r_avg       <= '0;
            r_mean      <= '0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (r_state == S_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_now  <= i_cmd.time_us;
                        r_ackn <= i_cmd.key;
                        case (i_cmd.op)
                            OP_SYN: begin
                                r_ev     <= (r_phase == 2'd0) ? EV_SYN : EV_NONE;
                                r_sample <= '0;
                                r_state  <= S_EMIT;
                                if (r_phase == 2'd0) begin
                                    r_syn_ts <= i_cmd.time_us;
                                    r_phase  <= 2'd1;
                                end
                            end
                            OP_SYNACK: begin
                                if (r_phase == 2'd1) begin
                                    r_sample <= f_elapsed(i_cmd.time_us, r_syn_ts);
                                    r_conn   <= f_elapsed(i_cmd.time_us, r_syn_ts);
                                    r_phase  <= 2'd2;
                                    r_ev     <= EV_CONN;
                                    r_state  <= S_AVG;
                                end else begin
                                    r_sample <= '0;
                                    r_ev     <= EV_NONE;
                                    r_state  <= S_EMIT;
                                end
                            end
                            OP_DATA: begin
                                r_sample <= '0;
                                r_state  <= S_EMIT;
                                if (r_total < CW'(PENDING_DEPTH)) begin
                                    r_total <= r_total + CW'(1);
                                    r_ev    <= EV_TRACKED;
                                end else begin
                                    r_ev <= EV_FULL;
                                end
                            end
                            OP_ACK: begin
                                r_ev     <= EV_NONE;
                                r_sample <= '0;
                                r_addr   <= '0;
                                r_dv     <= 1'b0;
                                r_found  <= 1'b0;
                                r_state  <= S_SCAN;
                            end
                            default: begin
                                r_ev     <= EV_NONE;
                                r_sample <= '0;
                                r_state  <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_match) begin
                        r_found  <= 1'b1;
                        r_sample <= f_elapsed(r_now, r_rdata.ts);
                    end
                    if (r_addr < r_total) begin
                        r_addr  <= r_addr + CW'(1);
                        r_dv    <= 1'b1;
                        r_daddr <= r_addr[AW-1:0];
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (!r_dv && r_addr == r_total) begin
                        if (r_found) begin
                            r_total <= r_total - CW'(1);
                            r_dsum  <= w_sum[TimeW] ? {TimeW{1'b1}} : w_sum[TimeW-1:0];
                            r_dvd   <= w_sum[TimeW] ? {TimeW{1'b1}} : w_sum[TimeW-1:0];
                            if (r_nsamp != {RttW{1'b1}}) begin
                                r_nsamp <= r_nsamp + RttW'(1);
                            end
                            r_rem   <= '0;
                            r_dcnt  <= '0;
                            r_ev    <= EV_DATA;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= w_qbit ? w_rem_sh - {1'b0, r_nsamp} : w_rem_sh;
                    r_dvd  <= {r_dvd[DivW-2:0], w_qbit};
                    r_dcnt <= r_dcnt + DcW'(1);
                    if (r_dcnt == DcW'(DivW - 1)) begin
                        r_mean  <= {r_dvd[DivW-2:0], w_qbit};
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    if (r_nsamp != '0 || r_conn != '0) begin
                        r_avg <= (w_v > TimeW'({RttW{1'b1}})) ? {RttW{1'b1}} : w_v[RttW-1:0];
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    o_res.event_res       <= r_ev;
                    o_res.sample_rtt_us   <= r_sample;
                    o_res.avg_valid       <= (r_conn != '0) || (r_nsamp != '0);
                    o_res.avg_rtt_us      <= ((r_conn != '0) || (r_nsamp != '0)) ? r_avg : '0;
                    o_res.pending_entries <= (32'(r_total) > 32'd255) ? {PendW{1'b1}}
                                                                      : PendW'(r_total);
                    r_state               <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid = r_out_valid;

endmodule

[sv/tcp_rtt_tracker_core.sv]
// TCP round-trip tracker for one session.
// i_seg carries one segment per beat (time, SYN/ACK flags, seq, ack, payload
// length); o_res returns exactly one result beat per segment, in order.
// Both channels use valid/ready; a beat moves when both are high.
// A two-entry command queue sits between the classifier and the executor, so
// segments keep arriving while a result waits in the output register.
// Steps per segment: SYN, data and empty segments go straight to the result;
//   a SYN/ACK that completes the handshake first updates the average.
//   ACK: the table is scanned and later entries shift down over a hit (one entry
//   per cycle through the table memory, one read and one write port); a hit
//   then runs the 48-bit bit-serial mean divider and the average update.
// The executor handles one segment at a time and pops no new command until the
// previous result beat has been taken.
// Reset (synchronous, active low) empties the queue and clears the handshake
// phase, counters, sums and average; the table needs no clear.
// When o_res stalls, the executor holds the finished beat and waits; the
// queue keeps taking up to two more segments before i_seg.ready drops.
module tcp_rtt_tracker_core
    import tcprtt_pkg::*;
#(
    parameter int PENDING_DEPTH = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcprtt_seg_if.sink    i_seg,
    tcprtt_res_if.source  o_res
);

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;

    tcprtt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg       (i_seg),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    tcprtt_back #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res       (o_res)
    );

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid && !o_res.valid)
        else $error("command popped while empty or result pending");

    a_sample_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.sample_rtt_us != '0 |->
            o_res.event_res == EV_CONN || o_res.event_res == EV_DATA)
        else $error("sample reported without an rtt event");

    a_avg_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.avg_valid |-> o_res.avg_rtt_us == '0)
        else $error("average shown before any rtt");

endmodule

[tb/tb.sv]
module tb;
    import tcprtt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 128;
    localparam logic [TimeW-1:0] T_MAX = {TimeW{1'b1}};
    localparam logic [RttW-1:0]  R_MAX = {RttW{1'b1}};

    typedef struct packed {
        logic [TimeW-1:0] time_us;
        logic             syn;
        logic             ack;
        logic [SeqW-1:0]  seq;
        logic [SeqW-1:0]  ackn;
        logic [LenW-1:0]  plen;
    } t_seg;

    typedef struct packed {
        logic [EvW-1:0]   ev;
        logic [RttW-1:0]  sample;
        logic [RttW-1:0]  avg;
        logic             avg_ok;
        logic [PendW-1:0] pend;
    } t_res;

    typedef struct packed {
        t_seg seg;
        logic known;
        t_res res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tcprtt_seg_if seg_if ();
    tcprtt_res_if res_if ();

    tcp_rtt_tracker_core #(.PENDING_DEPTH(DEPTH)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [1:0]       hs_phase;
    logic [TimeW-1:0] syn_ts;
    logic [RttW-1:0]  conn_rtt;
    logic [SeqW-1:0]  pend_seq [DEPTH];
    logic [TimeW-1:0] pend_ts [DEPTH];
    int               pend_cnt;
    logic [TimeW-1:0] data_sum;
    logic [RttW-1:0]  data_cnt;
    logic [RttW-1:0]  avg_reg;

    t_res expected_results[$];
    int   fail_cnt = 0;
    int   send_pct = 0;
    int   recv_pct = 0;
    int   hold_cycles = 0;
    logic [TimeW-1:0] now_us = '0;

    function automatic logic [RttW-1:0] elapsed(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
        logic [TimeW-1:0] d;
        d = (a >= b) ? a - b : '0;
        return (d > TimeW'(R_MAX)) ? R_MAX : d[RttW-1:0];
    endfunction

    function automatic void refresh_avg();
        logic [TimeW:0] v;
        logic [TimeW-1:0] mean;
        if (data_cnt != 0) begin
            mean = data_sum / data_cnt;
            v = (conn_rtt != 0) ? ({1'b0, mean} + conn_rtt) >> 1 : {1'b0, mean};
        end else if (conn_rtt != 0) begin
            v = (TimeW + 1)'(conn_rtt);
        end else begin
            return;
        end
        avg_reg = (v > R_MAX) ? R_MAX : v[RttW-1:0];
    endfunction

    function automatic t_res predict_segment(t_seg s);
        t_res r;
        logic [TimeW:0] sum;
        r = '0;
        if (s.syn && !s.ack) begin
            if (hs_phase == 0) begin
                syn_ts = s.time_us;
                hs_phase = 1;
                r.ev = EV_SYN;
            end
        end else if (s.syn) begin
            if (hs_phase == 1) begin
                r.sample = elapsed(s.time_us, syn_ts);
                conn_rtt = r.sample;
                hs_phase = 2;
                r.ev = EV_CONN;
                refresh_avg();
            end
        end else if (!s.ack) begin
            if (s.plen != 0) begin
                if (pend_cnt < DEPTH) begin
                    pend_seq[pend_cnt] = s.seq;
                    pend_ts[pend_cnt] = s.time_us;
                    pend_cnt++;
                    r.ev = EV_TRACKED;
                end else begin
                    r.ev = EV_FULL;
                end
            end
        end else begin
            for (int i = 0; i < pend_cnt; i++) begin
                if (s.ackn > pend_seq[i]) begin
                    r.sample = elapsed(s.time_us, pend_ts[i]);
                    sum = data_sum + r.sample;
                    data_sum = (sum > T_MAX) ? T_MAX : sum[TimeW-1:0];
                    if (data_cnt != R_MAX) data_cnt++;
                    for (int j = i; j + 1 < pend_cnt; j++) begin
                        pend_seq[j] = pend_seq[j+1];
                        pend_ts[j] = pend_ts[j+1];
                    end
                    pend_cnt--;
                    r.ev = EV_DATA;
                    refresh_avg();
                    break;
                end
            end
        end
        r.avg_ok = (conn_rtt != 0) || (data_cnt != 0);
        r.avg = r.avg_ok ? avg_reg : '0;
        r.pend = PendW'(pend_cnt);
        return r;
    endfunction

    task automatic send_segment(t_seg s, logic known, t_res want);
        t_res p;
        while (send_pct > 0 && $urandom_range(99) < send_pct) begin
            seg_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        seg_if.valid       <= 1'b1;
        seg_if.time_us     <= s.time_us;
        seg_if.syn_flag    <= s.syn;
        seg_if.ack_flag    <= s.ack;
        seg_if.seq_number  <= s.seq;
        seg_if.ack_number  <= s.ackn;
        seg_if.payload_len <= s.plen;
        do @(posedge i_clk); while (!seg_if.ready);
        p = predict_segment(s);
        if (known && p !== want) begin
            $display("%0t directed row: table %h predictor %h", $time, want, p);
            fail_cnt++;
        end
        expected_results.push_back(p);
        @(negedge i_clk);
    endtask

    function automatic t_seg rand_segment();
        t_seg s;
        int k;
        s.time_us = now_us;
        s.seq  = $urandom_range(200);
        s.ackn = $urandom_range(220);
        s.plen = $urandom_range(3) == 0 ? 16'd0 : LenW'($urandom);
        k = $urandom_range(99);
        s.syn = k < 8;
        s.ack = (k < 4) || (k >= 50);
        if ($urandom_range(40) == 0) begin
            s.time_us = TimeW'({$urandom, $urandom});
            s.seq = $urandom;
            s.ackn = $urandom;
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected beat: actual %h", $time,
                         {res_if.event_res, res_if.sample_rtt_us, res_if.avg_rtt_us,
                          res_if.avg_valid, res_if.pending_entries});
                fail_cnt++;
            end else begin
                t_res w;
                w = expected_results.pop_front();
                if (res_if.event_res !== w.ev || res_if.sample_rtt_us !== w.sample ||
                    res_if.avg_rtt_us !== w.avg || res_if.avg_valid !== w.avg_ok ||
                    res_if.pending_entries !== w.pend) begin
                    $display("%0t mismatch: expected ev=%0d smp=%0d avg=%0d v=%0d pend=%0d",
                             $time, w.ev, w.sample, w.avg, w.avg_ok, w.pend);
                    $display("%0t            actual ev=%0d smp=%0d avg=%0d v=%0d pend=%0d",
                             $time, res_if.event_res, res_if.sample_rtt_us,
                             res_if.avg_rtt_us, res_if.avg_valid, res_if.pending_entries);
                    fail_cnt++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !(recv_pct > 0 && $urandom_range(99) < recv_pct);
        end
    end

    function automatic t_row mk(logic [TimeW-1:0] t, logic sy, logic ak, logic [SeqW-1:0] sq,
                                logic [SeqW-1:0] an, logic [LenW-1:0] pl, logic kn,
                                logic [EvW-1:0] ev, logic [RttW-1:0] smp,
                                logic [RttW-1:0] av, logic ok, logic [PendW-1:0] pe);
        t_row r;
        r.seg = '{t, sy, ak, sq, an, pl};
        r.known = kn;
        r.res = '{ev, smp, av, ok, pe};
        return r;
    endfunction

    initial begin
        t_row rows[$];
        t_seg s;
        seg_if.valid = 1'b0;
        seg_if.time_us = '0;
        seg_if.syn_flag = 1'b0;
        seg_if.ack_flag = 1'b0;
        seg_if.seq_number = '0;
        seg_if.ack_number = '0;
        seg_if.payload_len = '0;
        hs_phase = 0; syn_ts = '0; conn_rtt = '0; pend_cnt = 0;
        data_sum = '0; data_cnt = '0; avg_reg = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back(mk(48'd10, 0, 1, 0, R_MAX, 0, 1, EV_NONE, 0, 0, 0, 0));
        rows.push_back(mk(48'd10, 0, 0, 5, 0, 0, 1, EV_NONE, 0, 0, 0, 0));
        rows.push_back(mk(48'd10, 1, 1, 0, 0, 1, 1, EV_NONE, 0, 0, 0, 0));
        rows.push_back(mk(48'd100, 1, 0, 0, 0, 0, 1, EV_SYN, 0, 0, 0, 0));
        rows.push_back(mk(48'd200, 1, 0, 0, 0, 0, 1, EV_NONE, 0, 0, 0, 0));
        rows.push_back(mk(48'd50, 1, 1, 0, 0, 0, 1, EV_CONN, 0, 0, 0, 0));
        rows.push_back(mk(48'd60, 1, 1, 0, 0, 0, 1, EV_NONE, 0, 0, 0, 0));
        rows.push_back(mk(48'd1000, 1, 0, 7, 0, 16'hFFFF, 1, EV_NONE, 0, 0, 0, 0));
        rows.push_back(mk(48'd1000, 0, 0, R_MAX, 0, 16'hFFFF, 1, EV_TRACKED, 0, 0, 0, 1));
        rows.push_back(mk(48'd1000, 0, 0, 0, 0, 1, 1, EV_TRACKED, 0, 0, 0, 2));
        rows.push_back(mk(48'd1500, 0, 1, 0, R_MAX, 0, 1, EV_DATA, 500, 500, 1, 1));
        rows.push_back(mk(48'd900, 0, 1, 0, R_MAX, 0, 1, EV_NONE, 0, 500, 1, 1));
        rows.push_back(mk(T_MAX, 0, 0, 3, 0, 9, 1, EV_TRACKED, 0, 500, 1, 2));
        rows.push_back(mk(48'd0, 0, 1, 0, 4, 0, 1, EV_DATA, 0, 250, 1, 1));
        rows.push_back(mk(48'd0, 0, 0, 100, 0, 2, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(T_MAX, 0, 1, 0, R_MAX, 0, 0, 0, 0, 0, 0, 0));
        foreach (rows[i]) send_segment(rows[i].seg, rows[i].known, rows[i].res);
        seg_if.valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (200) @(negedge i_clk);

        s = '0;
        for (int i = 0; i < DEPTH + 2; i++) begin
            s.plen = 1; s.seq = i; s.time_us = T_MAX - 48'd5;
            send_segment(s, 0, '0);
        end
        s.ack = 1; s.ackn = R_MAX; s.time_us = 48'd1;
        send_segment(s, 0, '0);
        s.time_us = T_MAX;
        send_segment(s, 0, '0);
        while (pend_cnt > 1) begin
            s.time_us = TimeW'({$urandom, $urandom});
            send_segment(s, 0, '0);
        end
        seg_if.valid <= 1'b0;
        wait (expected_results.size() == 0);
        @(negedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            send_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 12 : 49) : 0;
            recv_pct = (ph == 2) ? 49 : (ph == 3 ? 12 : 0);
            if (ph == 1) hold_cycles = 3000;
            for (int n = 0; n < 260; n++) begin
                now_us = now_us + $urandom_range(5000);
                send_segment(rand_segment(), 0, '0);
            end
            seg_if.valid <= 1'b0;
            wait (expected_results.size() == 0);
            @(negedge i_clk);
        end
        repeat (300) @(negedge i_clk);
        if (fail_cnt == 0 && expected_results.size() == 0)
            $display("** tcp_rtt_tracker_core: PASSED **");
        else
            $display("** tcp_rtt_tracker_core: FAILED **");
        $finish;
    end

    initial begin
        #20ms;
        $display("** tcp_rtt_tracker_core: FAILED **");
        $finish;
    end
endmodule

[filelist.f]
sv/tcprtt_pkg.sv
sv/tcprtt_if.sv
sv/tcprtt_front.sv
sv/tcprtt_back.sv
sv/tcp_rtt_tracker_core.sv
tb/tb.sv
